// ----- hdl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/fsg_pkg.sv -----
// shared types and constants of the falling sand grid
`default_nettype none

package fsg_pkg;

    localparam int GRID_DIM  = 128;
    localparam int IDX_W     = $clog2(GRID_DIM);
    localparam int ADDR_W    = $clog2(GRID_DIM * GRID_DIM);
    localparam int CNT_W     = $clog2(GRID_DIM + 1);
    localparam int FIELD_W   = 7;
    localparam int COLOR_W   = 24;
    localparam int CLEAR_W   = 8;
    localparam logic [31:0] RANDOM_SEED = 32'hdeadbeef;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_SWEEP = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RD_HOST   = 2'd0,
        RD_BOTTOM = 2'd1,
        RD_ROW    = 2'd2,
        RD_PREV   = 2'd3
    } occ_rd_src_t;

    typedef enum logic [1:0] {
        WR_HOST  = 2'd0,
        WR_ZERO  = 2'd1,
        WR_BELOW = 2'd2,
        WR_LAST  = 2'd3
    } occ_wr_src_t;

    typedef struct packed {
        logic        host_write;
        logic        host_capture;
        logic        occ_rd;
        occ_rd_src_t occ_rd_src;
        logic        occ_wr;
        occ_wr_src_t occ_wr_src;
        logic        row_load_sweep;
        logic        row_load_bottom;
        logic        row_dec;
        logic        cnt_load;
        logic        cnt_dec;
        logic        below_from_rd;
        logic        cur_from_rd;
        logic        shift;
        logic        col_init;
        logic        visit;
        logic        out_load;
        logic        out_read;
    } dp_cmd_t;

    typedef struct packed {
        logic col_last;
        logic row_zero;
        logic cnt_zero;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/fsg_ctrl.sv -----
// controller state machine sequencing requests, sweeps and clears
`default_nettype none

module fsg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    output logic                out_valid,
    input  logic                out_ready,
    input  fsg_pkg::dp_status_t status,
    output fsg_pkg::dp_cmd_t    cmd
);
    import fsg_pkg::*;

    typedef enum logic [8:0] {
        S_INIT     = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_CLEAR    = 9'b000000100,
        S_SW_RD1   = 9'b000001000,
        S_SW_LD    = 9'b000010000,
        S_SW_CELL  = 9'b000100000,
        S_SW_END   = 9'b001000000,
        S_SW_FLUSH = 9'b010000000,
        S_RESULT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   read_reg;
    logic   read_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    op_t    op;

    assign op        = op_t'(operation);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        read_next  = read_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.occ_wr     = 1'b1;
                cmd.occ_wr_src = WR_ZERO;
                cmd.row_dec    = 1'b1;
                if (status.row_zero)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        OP_WRITE:
                        begin
                            cmd.host_write = 1'b1;
                            cmd.occ_wr     = 1'b1;
                            cmd.occ_wr_src = WR_HOST;
                            read_next      = 1'b0;
                            state_next     = S_RESULT;
                        end
                        OP_READ:
                        begin
                            cmd.occ_rd       = 1'b1;
                            cmd.occ_rd_src   = RD_HOST;
                            cmd.host_capture = 1'b1;
                            read_next        = 1'b1;
                            state_next       = S_RESULT;
                        end
                        OP_SWEEP:
                        begin
                            cmd.occ_rd         = 1'b1;
                            cmd.occ_rd_src     = RD_BOTTOM;
                            cmd.row_load_sweep = 1'b1;
                            read_next          = 1'b0;
                            state_next         = S_SW_RD1;
                        end
                        OP_CLEAR:
                        begin
                            cmd.cnt_load        = 1'b1;
                            cmd.row_load_bottom = 1'b1;
                            read_next           = 1'b0;
                            state_next          = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (status.cnt_zero)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.occ_wr     = 1'b1;
                    cmd.occ_wr_src = WR_ZERO;
                    cmd.row_dec    = 1'b1;
                    cmd.cnt_dec    = 1'b1;
                end
            end
            S_SW_RD1:
            begin
                cmd.occ_rd        = 1'b1;
                cmd.occ_rd_src    = RD_ROW;
                cmd.below_from_rd = 1'b1;
                state_next        = S_SW_LD;
            end
            S_SW_LD:
            begin
                cmd.cur_from_rd = 1'b1;
                cmd.col_init    = 1'b1;
                state_next      = S_SW_CELL;
            end
            S_SW_CELL:
            begin
                cmd.visit = 1'b1;
                if (status.col_last)
                begin
                    state_next = S_SW_END;
                end
            end
            S_SW_END:
            begin
                cmd.occ_wr     = 1'b1;
                cmd.occ_wr_src = WR_BELOW;
                cmd.shift      = 1'b1;
                if (status.row_zero)
                begin
                    state_next = S_SW_FLUSH;
                end
                else
                begin
                    cmd.row_dec    = 1'b1;
                    cmd.occ_rd     = 1'b1;
                    cmd.occ_rd_src = RD_PREV;
                    state_next     = S_SW_LD;
                end
            end
            S_SW_FLUSH:
            begin
                cmd.occ_wr     = 1'b1;
                cmd.occ_wr_src = WR_LAST;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_read = read_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            read_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            read_reg      <= read_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fsg_dp.sv -----
// datapath with grid memories, row buffers, cell decision and coin generator
`default_nettype none

module fsg_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fsg_pkg::dp_cmd_t                    cmd,
    output fsg_pkg::dp_status_t                 status,
    input  logic [fsg_pkg::FIELD_W-1:0]         row,
    input  logic [fsg_pkg::FIELD_W-1:0]         column,
    input  logic                                occupied_in,
    input  logic [fsg_pkg::COLOR_W-1:0]         color_in,
    input  logic [fsg_pkg::CLEAR_W-1:0]         clear_rows,
    output logic                                occupied_out,
    output logic [fsg_pkg::COLOR_W-1:0]         color_out
);
    import fsg_pkg::*;

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    logic [GRID_DIM-1:0] occ_mem [GRID_DIM];
    logic [COLOR_W-1:0]  color_mem [GRID_DIM * GRID_DIM];

    logic [GRID_DIM-1:0] occ_rdata_reg;
    logic [COLOR_W-1:0]  color_rdata_reg;

    logic [GRID_DIM-1:0] cur_reg, cur_next;
    logic [GRID_DIM-1:0] below_reg, below_next;
    logic [IDX_W-1:0]    row_reg, row_next;
    logic [IDX_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [31:0]         rnd_reg, rnd_next;
    logic                cmove_reg, cmove_next;
    logic [ADDR_W-1:0]   cto_reg, cto_next;
    logic                inside_reg, inside_next;
    logic                occ_out_reg, occ_out_next;
    logic [COLOR_W-1:0]  color_out_reg, color_out_next;

    logic                host_inside;
    logic [IDX_W-1:0]    host_row;
    logic [IDX_W-1:0]    host_col;
    logic [ADDR_W-1:0]   host_addr;

    logic                occ_we;
    logic [IDX_W-1:0]    occ_waddr;
    logic [GRID_DIM-1:0] occ_wdata;
    logic [GRID_DIM-1:0] occ_wmask;
    logic [IDX_W-1:0]    occ_raddr;

    logic                color_we;
    logic [ADDR_W-1:0]   color_waddr;
    logic [COLOR_W-1:0]  color_wdata;
    logic                color_re;
    logic [ADDR_W-1:0]   color_raddr;

    logic                here_bit;
    logic                edge_l;
    logic                edge_r;
    logic                below_c;
    logic                below_l;
    logic                below_r;
    logic [31:0]         s_left;
    logic [31:0]         rnd_mid;
    logic [31:0]         s_right;
    logic [31:0]         rnd_after;
    logic                move;
    logic [IDX_W-1:0]    tcol;
    logic [ADDR_W-1:0]   here_addr;
    logic [ADDR_W-1:0]   tgt_addr;

    // host addressing
    assign host_inside = (int'(row) < GRID_DIM) && (int'(column) < GRID_DIM);
    assign host_row    = IDX_W'(row);
    assign host_col    = IDX_W'(column);
    assign host_addr   = ADDR_W'(int'(host_row) * GRID_DIM + int'(host_col));

    // cell decision
    assign here_bit = cur_reg[col_reg];
    assign edge_l   = (col_reg == '0);
    assign edge_r   = (col_reg == IDX_W'(GRID_DIM - 1));
    assign below_c  = below_reg[col_reg];
    assign below_l  = edge_l ? 1'b1 : below_reg[col_reg - 1'b1];
    assign below_r  = edge_r ? 1'b1 : below_reg[col_reg + 1'b1];
    assign s_left   = xorshift(rnd_reg);
    assign rnd_mid  = below_l ? rnd_reg : s_left;
    assign s_right  = xorshift(rnd_mid);

    always_comb
    begin
        move      = 1'b0;
        tcol      = col_reg;
        rnd_after = rnd_reg;
        if (here_bit && !edge_r)
        begin
            if (!below_c)
            begin
                move = 1'b1;
            end
            else if (!below_l && s_left[0])
            begin
                move      = 1'b1;
                tcol      = col_reg - 1'b1;
                rnd_after = s_left;
            end
            else if (!below_r)
            begin
                move      = s_right[0];
                tcol      = col_reg + 1'b1;
                rnd_after = s_right;
            end
            else
            begin
                rnd_after = rnd_mid;
            end
        end
    end

    assign here_addr = ADDR_W'(int'(row_reg) * GRID_DIM + int'(col_reg));
    assign tgt_addr  = ADDR_W'((int'(row_reg) + 1) * GRID_DIM + int'(tcol));

    // occupied row memory ports
    always_comb
    begin
        occ_waddr = row_reg;
        occ_wdata = '0;
        occ_wmask = '1;
        unique case (cmd.occ_wr_src)
            WR_HOST:
            begin
                occ_waddr = host_row;
                occ_wdata = {GRID_DIM{occupied_in}};
                occ_wmask = {{(GRID_DIM - 1){1'b0}}, 1'b1} << host_col;
            end
            WR_ZERO:
            begin
                occ_waddr = row_reg;
                occ_wdata = '0;
            end
            WR_BELOW:
            begin
                occ_waddr = row_reg + 1'b1;
                occ_wdata = below_reg;
            end
            WR_LAST:
            begin
                occ_waddr = row_reg;
                occ_wdata = below_reg;
            end
        endcase
    end

    assign occ_we = cmd.occ_wr && ((cmd.occ_wr_src != WR_HOST) || host_inside);

    always_comb
    begin
        unique case (cmd.occ_rd_src)
            RD_HOST:   occ_raddr = host_row;
            RD_BOTTOM: occ_raddr = IDX_W'(GRID_DIM - 1);
            RD_ROW:    occ_raddr = row_reg;
            RD_PREV:   occ_raddr = row_reg - 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            for (int i = 0; i < GRID_DIM; i++)
            begin
                if (occ_wmask[i])
                begin
                    occ_mem[occ_waddr][i] <= occ_wdata[i];
                end
            end
        end
        if (cmd.occ_rd)
        begin
            occ_rdata_reg <= occ_mem[occ_raddr];
        end
    end

    // color memory ports, a move writes in the cycle after its read
    assign color_we    = (cmd.host_write && host_inside) || cmove_reg;
    assign color_waddr = cmove_reg ? cto_reg : host_addr;
    assign color_wdata = cmove_reg ? color_rdata_reg : color_in;
    assign color_re    = (cmd.visit && move) || cmd.host_capture;
    assign color_raddr = cmd.visit ? here_addr : host_addr;

    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[color_waddr] <= color_wdata;
        end
        if (color_re)
        begin
            color_rdata_reg <= color_mem[color_raddr];
        end
    end

    // next state of buffers and counters
    always_comb
    begin
        cur_next       = cur_reg;
        below_next     = below_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        rnd_next       = rnd_reg;
        cmove_next     = cmd.visit && move;
        cto_next       = cto_reg;
        inside_next    = inside_reg;
        occ_out_next   = occ_out_reg;
        color_out_next = color_out_reg;

        if (cmd.cur_from_rd)
        begin
            cur_next = occ_rdata_reg;
        end
        if (cmd.below_from_rd)
        begin
            below_next = occ_rdata_reg;
        end
        if (cmd.shift)
        begin
            below_next = cur_reg;
        end
        if (cmd.visit)
        begin
            rnd_next = rnd_after;
            col_next = row_reg[0] ? col_reg - 1'b1 : col_reg + 1'b1;
            if (move)
            begin
                cur_next[col_reg] = 1'b0;
                below_next[tcol]  = 1'b1;
                cto_next          = tgt_addr;
            end
        end

        if (cmd.row_load_sweep)
        begin
            row_next = IDX_W'(GRID_DIM - 2);
        end
        else if (cmd.row_load_bottom)
        begin
            row_next = IDX_W'(GRID_DIM - 1);
        end
        else if (cmd.row_dec)
        begin
            row_next = row_reg - 1'b1;
        end

        if (cmd.col_init)
        begin
            col_next = row_reg[0] ? IDX_W'(GRID_DIM - 1) : '0;
        end
        if (cmd.host_capture)
        begin
            col_next    = host_col;
            inside_next = host_inside;
        end

        if (cmd.cnt_load)
        begin
            if (int'(clear_rows) > GRID_DIM)
            begin
                cnt_next = CNT_W'(GRID_DIM);
            end
            else
            begin
                cnt_next = CNT_W'(clear_rows);
            end
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.out_load)
        begin
            occ_out_next   = cmd.out_read && inside_reg && occ_rdata_reg[col_reg];
            color_out_next = (cmd.out_read && inside_reg) ? color_rdata_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= IDX_W'(GRID_DIM - 1);
            col_reg   <= '0;
            cnt_reg   <= '0;
            rnd_reg   <= RANDOM_SEED;
            cmove_reg <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            cmove_reg <= cmove_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        below_reg     <= below_next;
        cto_reg       <= cto_next;
        inside_reg    <= inside_next;
        occ_out_reg   <= occ_out_next;
        color_out_reg <= color_out_next;
    end

    assign status.col_last = row_reg[0] ? edge_l : edge_r;
    assign status.row_zero = (row_reg == '0);
    assign status.cnt_zero = (cnt_reg == '0);

    assign occupied_out = occ_out_reg;
    assign color_out    = color_out_reg;

endmodule

`default_nettype wire

// ----- hdl/falling_sand_grid_sweep.sv -----
// top level of the falling sand grid with its configuration register
//
//   channel   signals                         direction
//   in        in_valid / in_ready + fields    request in
//   out       out_valid / out_ready + fields  result out
//   cfg       apb psel/penable/pwrite ...     register write and read
//
// write and read: accepted in idle, the result is loaded once the output register is free
// sweep: one cell per cycle plus a row load and a row write-back per row
//   through the occupied row memory
// clear: clear_rows_count rows from the bottom, capped at GRID_DIM, one row per cycle
// after reset a clearing pass empties every row of the occupied memory
// a request is taken while an earlier result waits; the next result waits for it
`default_nettype none
`include "assert_macros.svh"

module falling_sand_grid_sweep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic [fsg_pkg::FIELD_W-1:0]         row,
    input  logic [fsg_pkg::FIELD_W-1:0]         column,
    input  logic                                occupied_in,
    input  logic [fsg_pkg::COLOR_W-1:0]         color_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                occupied_out,
    output logic [fsg_pkg::COLOR_W-1:0]         color_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import fsg_pkg::*;

    localparam logic REG_CLEAR_ROWS = 1'b0;
    localparam logic [CLEAR_W-1:0] CLEAR_ROWS_RESET = CLEAR_W'(10);

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic [CLEAR_W-1:0]  clear_rows_reg;
    logic [CLEAR_W-1:0]  clear_rows_next;
    logic                cfg_sel;
    logic                cfg_write;

    assign cfg_sel   = (paddr[2] == REG_CLEAR_ROWS);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = cfg_sel ? 32'(clear_rows_reg) : '0;

    always_comb
    begin
        clear_rows_next = clear_rows_reg;
        if (cfg_write && cfg_sel)
        begin
            clear_rows_next = pwdata[CLEAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_rows_reg <= CLEAR_ROWS_RESET;
        end
        else
        begin
            clear_rows_reg <= clear_rows_next;
        end
    end

    fsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fsg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .row          (row),
        .column       (column),
        .occupied_in  (occupied_in),
        .color_in     (color_in),
        .clear_rows   (clear_rows_reg),
        .occupied_out (occupied_out),
        .color_out    (color_out)
    );

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "not busy")
    `ASSERT_IMPLIES(a_no_result_lost, clk, rst_n, cmd.out_load, !out_valid || out_ready, "lost")
    `ASSERT_IMPLIES(a_no_write_in_visit, clk, rst_n, cmd.visit, !cmd.occ_wr, "row write in visit")

endmodule

`default_nettype wire

// ----- dv/tb_falling_sand_grid_sweep.sv -----
// self-checking testbench of the falling sand grid: predicts each result and compares it
module tb_falling_sand_grid_sweep;
    timeunit 1ns;
    timeprecision 1ps;

    import fsg_pkg::*;

    localparam int         CELLS           = GRID_DIM * GRID_DIM;
    localparam int         STALL_LIMIT     = 100000;
    localparam int         SETTLE_CYCLES   = 8;
    localparam logic [2:0] CLEAR_ROWS_ADDR = 3'd0;
    localparam logic [2:0] UNMAPPED_ADDR   = 3'd4;

    typedef struct {
        op_t                op;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] column;
        logic               occ;
        logic [COLOR_W-1:0] color;
    } sand_request_t;

    typedef struct {
        logic               occ;
        logic [COLOR_W-1:0] color;
    } cell_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         operation;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] column;
    logic               occupied_in;
    logic [COLOR_W-1:0] color_in;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               occupied_out;
    logic [COLOR_W-1:0] color_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // predicted grid state
    bit                 grain_map [CELLS];
    logic [COLOR_W-1:0] color_map [CELLS];
    bit                 color_known [CELLS];
    int                 known_cells [$];
    logic [31:0]        coin_state;
    logic [7:0]         clear_rows;

    cell_result_t       expected_cells [$];
    int                 errors = 0;
    int                 stall_cycles = 0;
    int                 ready_hold = 0;
    int                 gap_burst = 0;
    int                 pile_col = 0;

    falling_sand_grid_sweep dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .row          (row),
        .column       (column),
        .occupied_in  (occupied_in),
        .color_in     (color_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .occupied_out (occupied_out),
        .color_out    (color_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    function automatic bit flip_coin();
        logic [31:0] s;
        s = coin_state;
        s ^= s << 13;
        s ^= s >> 17;
        s ^= s << 5;
        coin_state = s;
        return s[0];
    endfunction

    function automatic void mark_known(int idx);
        if (!color_known[idx])
        begin
            color_known[idx] = 1'b1;
            known_cells.push_back(idx);
        end
    endfunction

    function automatic void move_grain(int from, int to);
        grain_map[from] = 1'b0;
        grain_map[to] = 1'b1;
        color_map[to] = color_map[from];
        mark_known(to);
    endfunction

    function automatic void settle_cell(int r, int c);
        int here;
        int below;
        here = r * GRID_DIM + c;
        below = here + GRID_DIM;
        if (!grain_map[here] || c >= GRID_DIM - 1)
            return;
        if (!grain_map[below])
        begin
            move_grain(here, below);
            return;
        end
        // column zero sees a solid wall on its left
        if (c > 0 && !grain_map[below - 1])
        begin
            if (flip_coin())
            begin
                move_grain(here, below - 1);
                return;
            end
        end
        if (!grain_map[below + 1])
        begin
            if (flip_coin())
                move_grain(here, below + 1);
        end
    endfunction

    function automatic cell_result_t grid_apply(op_t op, logic [FIELD_W-1:0] r,
                                                logic [FIELD_W-1:0] c, logic occ,
                                                logic [COLOR_W-1:0] color);
        cell_result_t res;
        int idx;
        int n;
        res.occ = 1'b0;
        res.color = '0;
        idx = int'(r) * GRID_DIM + int'(c);
        case (op)
            OP_WRITE:
            begin
                grain_map[idx] = occ;
                color_map[idx] = color;
                mark_known(idx);
            end
            OP_READ:
            begin
                res.occ = grain_map[idx];
                res.color = color_map[idx];
            end
            OP_SWEEP:
            begin
                for (int y = GRID_DIM - 2; y >= 0; y--)
                begin
                    if (y % 2 == 0)
                    begin
                        for (int x = 0; x < GRID_DIM; x++)
                            settle_cell(y, x);
                    end
                    else
                    begin
                        for (int x = GRID_DIM - 1; x >= 0; x--)
                            settle_cell(y, x);
                    end
                end
            end
            default:
            begin
                n = (int'(clear_rows) > GRID_DIM) ? GRID_DIM : int'(clear_rows);
                for (int k = (GRID_DIM - n) * GRID_DIM; k < CELLS; k++)
                    grain_map[k] = 1'b0;
            end
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (gap_burst > 0)
        begin
            gap_burst--;
            return 0;
        end
        if (pick < 10)
        begin
            gap_burst = $urandom_range(5, 20);
            return 0;
        end
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: stall patterns with long and short gaps
    always @(posedge clk)
    begin
        int pick;
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                out_ready <= 1'b1;
                ready_hold <= $urandom_range(0, 30);
            end
            else if (pick < 95)
            begin
                out_ready <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end
            else
            begin
                out_ready <= 1'b0;
                ready_hold <= $urandom_range(20, 80);
            end
        end
    end

    always @(posedge clk)
    begin
        cell_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got occupied %0b color %06h",
                         $time, occupied_out, color_out);
                errors++;
            end
            else
            begin
                exp_res = expected_cells.pop_front();
                if (occupied_out !== exp_res.occ)
                begin
                    $display("%0t: occupied_out mismatch: expected %0b, got %0b",
                             $time, exp_res.occ, occupied_out);
                    errors++;
                end
                if (color_out !== exp_res.color)
                begin
                    $display("%0t: color_out mismatch: expected %06h, got %06h",
                             $time, exp_res.color, color_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
            $display("falling_sand_grid_sweep verification failed");
            $finish;
        end
    end

    task automatic send_request(op_t op, logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] c,
                                logic occ, logic [COLOR_W-1:0] color);
        cell_result_t exp_res;
        int gap;
        gap = pick_gap();
        exp_res = grid_apply(op, r, c, occ, color);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        row <= r;
        column <= c;
        occupied_in <= occ;
        color_in <= color;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_cells.push_back(exp_res);
    endtask

    // stop sending and wait for every outstanding result
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] data);
        logic [31:0] unused;
        apb_access(1'b1, addr, data, unused);
        if (addr == CLEAR_ROWS_ADDR)
            clear_rows = data[7:0];
    endtask

    task automatic check_clear_rows();
        logic [31:0] rdata;
        apb_access(1'b0, CLEAR_ROWS_ADDR, '0, rdata);
        if (rdata !== 32'(clear_rows))
        begin
            $display("%0t: clear_rows_count readback mismatch: expected %08h, got %08h",
                     $time, 32'(clear_rows), rdata);
            errors++;
        end
    endtask

    function automatic sand_request_t random_request();
        sand_request_t req;
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        req.row = FIELD_W'($urandom);
        req.column = FIELD_W'($urandom);
        req.occ = 1'($urandom);
        req.color = COLOR_W'($urandom);
        if (pick < 45)
        begin
            req.op = OP_WRITE;
            if ($urandom_range(0, 4) != 0)
            begin
                req.row = FIELD_W'($urandom_range(GRID_DIM - 12, GRID_DIM - 1));
                req.column = FIELD_W'(pile_col + $urandom_range(0, 7));
            end
            req.occ = ($urandom_range(0, 6) != 0);
        end
        else if (pick < 82)
        begin
            req.op = OP_READ;
            if ($urandom_range(0, 4) != 0)
            begin
                req.row = FIELD_W'($urandom_range(GRID_DIM - 12, GRID_DIM - 1));
                req.column = FIELD_W'(pile_col + $urandom_range(0, 7));
            end
            idx = int'(req.row) * GRID_DIM + int'(req.column);
            // colours never written are unknown, so read a known cell instead
            if (!color_known[idx])
            begin
                idx = known_cells[$urandom_range(0, known_cells.size() - 1)];
                req.row = FIELD_W'(idx / GRID_DIM);
                req.column = FIELD_W'(idx % GRID_DIM);
            end
        end
        else if (pick < 96)
            req.op = OP_SWEEP;
        else
            req.op = OP_CLEAR;
        return req;
    endfunction

    task automatic test_register_access();
        // let the power-up clearing pass finish
        repeat (GRID_DIM + 10) @(posedge clk);
        check_clear_rows();
        write_register(CLEAR_ROWS_ADDR, 32'hffff_ff80);
        check_clear_rows();
        write_register(UNMAPPED_ADDR, 32'h0000_0033);
        check_clear_rows();
    endtask

    task automatic test_cell_access();
        send_request(OP_WRITE, 7'd0, 7'd0, 1'b1, 24'hffffff);
        send_request(OP_WRITE, 7'd127, 7'd127, 1'b1, 24'h000000);
        send_request(OP_WRITE, 7'd127, 7'd0, 1'b1, 24'h5a5a5a);
        send_request(OP_WRITE, 7'd64, 7'd63, 1'b0, 24'ha5a5a5);
        send_request(OP_READ, 7'd0, 7'd0, 1'b0, 24'h000000);
        send_request(OP_READ, 7'd127, 7'd127, 1'b1, 24'hffffff);
        send_request(OP_READ, 7'd64, 7'd63, 1'b1, 24'h123456);
    endtask

    task automatic test_grain_motion();
        send_request(OP_WRITE, 7'd125, 7'd10, 1'b1, 24'h0a0b0c);
        send_request(OP_WRITE, 7'd126, 7'd0, 1'b1, 24'h102030);
        send_request(OP_WRITE, 7'd120, 7'd127, 1'b1, 24'hc0ffee);
        send_request(OP_WRITE, 7'd127, 7'd20, 1'b1, 24'h111111);
        send_request(OP_WRITE, 7'd126, 7'd20, 1'b1, 24'h222222);
        send_request(OP_WRITE, 7'd125, 7'd20, 1'b1, 24'h333333);
        send_request(OP_SWEEP, 7'd0, 7'd0, 1'b0, 24'h000000);
        send_request(OP_SWEEP, 7'd127, 7'd127, 1'b1, 24'hffffff);
        send_request(OP_READ, 7'd127, 7'd10, 1'b0, 24'h000000);
        send_request(OP_READ, 7'd126, 7'd0, 1'b0, 24'h000000);
        send_request(OP_READ, 7'd120, 7'd127, 1'b0, 24'h000000);
        send_request(OP_READ, 7'd125, 7'd20, 1'b0, 24'h000000);
    endtask

    task automatic test_row_clear();
        quiesce();
        write_register(CLEAR_ROWS_ADDR, 32'd0);
        send_request(OP_CLEAR, 7'd5, 7'd9, 1'b1, 24'h00ff00);
        send_request(OP_READ, 7'd127, 7'd127, 1'b0, 24'h000000);
        quiesce();
        write_register(CLEAR_ROWS_ADDR, 32'd255);
        check_clear_rows();
        send_request(OP_CLEAR, 7'd0, 7'd0, 1'b0, 24'h000000);
        send_request(OP_READ, 7'd127, 7'd0, 1'b0, 24'h000000);
    endtask

    task automatic test_random_traffic();
        sand_request_t req;
        for (int phase = 0; phase < 4; phase++)
        begin
            quiesce();
            case (phase)
                0: write_register(CLEAR_ROWS_ADDR, 32'd128);
                1: write_register(CLEAR_ROWS_ADDR, 32'd1);
                2: write_register(CLEAR_ROWS_ADDR, 32'($urandom_range(2, 254)));
                default: write_register(CLEAR_ROWS_ADDR, 32'd10);
            endcase
            case ($urandom_range(0, 2))
                0: pile_col = 0;
                1: pile_col = GRID_DIM - 8;
                default: pile_col = $urandom_range(1, GRID_DIM - 9);
            endcase
            for (int n = 0; n < 25; n++)
            begin
                if (phase == 1 && n == 12)
                    quiesce();
                req = random_request();
                send_request(req.op, req.row, req.column, req.occ, req.color);
            end
        end
    endtask

    initial
    begin
        in_valid = 1'b0;
        operation = OP_WRITE;
        row = '0;
        column = '0;
        occupied_in = 1'b0;
        color_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        coin_state = RANDOM_SEED;
        clear_rows = 8'd10;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_register_access();
        test_cell_access();
        test_grain_motion();
        test_row_clear();
        test_random_traffic();
        quiesce();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("falling_sand_grid_sweep verification clean");
        else
            $display("falling_sand_grid_sweep verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/fsg_pkg.sv
hdl/fsg_ctrl.sv
hdl/fsg_dp.sv
hdl/falling_sand_grid_sweep.sv
dv/tb_falling_sand_grid_sweep.sv
